>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion helpers shared by the RTL
// Clocked property checks, all disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define OLWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another condition in the next cycle.
`define OLWS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/olws_pkg.sv
// ---------------------------------------------------------------------------
// olws_pkg
// Request and result types, request and status codes, cell control.
// ---------------------------------------------------------------------------
package olws_pkg;

    localparam logic [1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [1:0] REQ_INS_END   = 2'd1;
    localparam logic [1:0] REQ_LIST      = 2'd2;
    localparam logic [1:0] REQ_SEARCH    = 2'd3;

    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_EMPTY     = 3'd2;
    localparam logic [2:0] STS_FOUND     = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_ELEMENT   = 3'd5;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_SHIFT  = 2'd1;
    localparam logic [1:0] CELL_APPEND = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] element;
        logic [6:0]         position;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

>>> src/olws_cell.sv
// ---------------------------------------------------------------------------
// olws_cell
// One list element. Shifts toward the tail on a front insert, loads on an
// append at its own position, and rotates toward the head during a walk.
// ---------------------------------------------------------------------------
module olws_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7
) (
    input  logic                      i_clk,
    input  olws_pkg::t_cell_ctl       i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [31:0]        i_prev,
    input  logic signed [31:0]        i_next,
    input  logic signed [31:0]        i_head,
    output logic signed [31:0]        o_data
);
    import olws_pkg::*;

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               w_at_count;
    logic               w_at_tail;

    assign w_at_count = (i_count == CW'(INDEX));
    assign w_at_tail  = (i_count == CW'(INDEX + 1));

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CELL_HOLD:   n_data = r_data;
            CELL_SHIFT:  n_data = i_prev;
            CELL_APPEND: if (w_at_count) n_data = i_ctl.value;
            // the tail cell closes the ring by taking the head
            CELL_ROTATE: n_data = w_at_tail ? i_head : i_next;
            default:     n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> src/ordered_list_with_search_top.sv
// ---------------------------------------------------------------------------
// ordered_list_with_search_top
// Ordered list of signed 32-bit values held in a chain of cells.
// ---------------------------------------------------------------------------
// Requests arrive on i_in (valid/stall); results leave on o_out (valid/stall).
// Between walks cell k holds list element k, so the head of the list is cell 0.
// Insert at front shifts the chain one cell toward the tail; insert at end
// loads the cell at the current count. Both answer in the cycle after
// acceptance with a single result; an insert into a full list answers full.
// List and search walk the chain: it rotates one cell per cycle, in a list
// only while unstalled, around the occupied part, presenting each element at
// cell 0, and is back in order after count steps. List puts out one element
// per cycle while unstalled, the last one flagged; search then gives a single
// result. An empty list answers empty in the cycle after acceptance.
// One request is in flight at a time: a new request is taken only in idle,
// once the result register is free, so a list or search walk must end first.
// While the receiver stalls a valid result, the result register holds and a list walk
// pauses; no new request is taken.
// Reset empties the list; cell contents are not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_with_search_top #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  olws_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output olws_pkg::t_out_item   o_out
);
    import olws_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LIST  = 2'd1;
    localparam logic [1:0] ST_SRCH  = 2'd2;
    localparam logic [1:0] ST_SDONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_step, n_step;
    logic signed [31:0] r_key, n_key;
    logic               r_found, n_found;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_cell_ctl          w_ctl;
    logic               w_out_free;
    logic               w_in_accept;
    logic               w_full;
    logic [CW-1:0]      w_step_inc;
    logic               w_walk_last;
    logic signed [31:0] w_data [CAPACITY];

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_step_inc  = r_step + CW'(1);
    assign w_walk_last = (w_step_inc == r_count);

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic signed [31:0] w_prev;
            logic signed [31:0] w_next;
            if (k == 0) begin : g_first
                assign w_prev = i_in.value;
            end else begin : g_inner_prev
                assign w_prev = w_data[k-1];
            end
            if (k == CAPACITY - 1) begin : g_final
                assign w_next = w_data[0];
            end else begin : g_inner_next
                assign w_next = w_data[k+1];
            end
            olws_cell #(
                .INDEX (k),
                .CW    (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_count (r_count),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .i_head  (w_data[0]),
                .o_data  (w_data[k])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_key       = r_key;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_ctl.op    = CELL_HOLD;
        w_ctl.value = i_in.value;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = STS_INSERTED;
                    n_out.element    = '0;
                    n_out.position   = '0;
                    n_out.last       = 1'b1;
                    n_step           = '0;
                    n_found          = 1'b0;
                    n_pos            = '0;
                    n_key            = i_in.value;
                    if (i_in.req_type == REQ_INS_FRONT || i_in.req_type == REQ_INS_END) begin
                        if (w_full) begin
                            n_out.status = STS_FULL;
                        end else begin
                            n_count  = r_count + CW'(1);
                            w_ctl.op = (i_in.req_type == REQ_INS_FRONT) ? CELL_SHIFT
                                                                       : CELL_APPEND;
                        end
                    end else if (r_count == '0) begin
                        n_out.status = STS_EMPTY;
                    end else begin
                        // results come from the walk
                        n_out_valid = 1'b0;
                        n_state     = (i_in.req_type == REQ_LIST) ? ST_LIST : ST_SRCH;
                    end
                end
            end
            ST_LIST: begin
                if (w_out_free) begin
                    w_ctl.op       = CELL_ROTATE;
                    n_out_valid    = 1'b1;
                    n_out.status   = STS_ELEMENT;
                    n_out.element  = w_data[0];
                    n_out.position = 7'(w_step_inc);
                    n_out.last     = w_walk_last;
                    n_step         = w_step_inc;
                    if (w_walk_last) n_state = ST_IDLE;
                end
            end
            ST_SRCH: begin
                // keep rotating after a hit so the chain ends in order
                w_ctl.op = CELL_ROTATE;
                n_step   = w_step_inc;
                if (!r_found && (w_data[0] == r_key)) begin
                    n_found = 1'b1;
                    n_pos   = w_step_inc;
                end
                if (w_walk_last) n_state = ST_SDONE;
            end
            ST_SDONE: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = r_found ? STS_FOUND : STS_NOT_FOUND;
                    n_out.element  = '0;
                    n_out.position = r_found ? 7'(r_pos) : 7'd0;
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pos <= n_pos;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `OLWS_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `OLWS_ASSERT(a_count_moves_on_insert,
                 (r_count == $past(r_count)) || $past(w_in_accept) || $past(!i_rst_n),
                 "entry count changed without an accepted request")
    `OLWS_ASSERT(a_walk_in_list, (r_state != ST_LIST && r_state != ST_SRCH) || (r_step < r_count),
                 "walk step outside the list")
    `OLWS_ASSERT_NEXT(a_list_ends_idle, r_state == ST_LIST && w_out_free && w_walk_last,
                      r_state == ST_IDLE && o_out_valid && o_out.last,
                      "list walk did not end on a flagged result")

endmodule

>>> tb/tb_ordered_list_with_search_top.sv
// ---------------------------------------------------------------------------
// tb_ordered_list_with_search_top
// Self-checking bench for the ordered list: a short directed pass through the
// empty-list answers, value extremes and duplicates, then random requests that
// grow the list to capacity and keep hitting it with rejected inserts, lists
// and searches. A scoreboard predicts every result and checks each one in
// order, under three sender and receiver idling mixes.
// ---------------------------------------------------------------------------
module tb_ordered_list_with_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olws_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = CAPACITY + 8;
    localparam int REPORT_LIMIT = 10;

    // Keeps its own copy of the list and the results still owed.
    class list_scoreboard;
        logic signed [31:0] cells [CAPACITY];
        int                 head;
        int                 count;
        t_out_item          owed_q [$];
        int                 fail_count;

        function new();
            head       = 0;
            count      = 0;
            fail_count = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Any value currently in the list, for searches that should hit.
        function logic signed [31:0] stored_value();
            return cells[(head + $urandom_range(count - 1)) % CAPACITY];
        endfunction

        function void note_request(t_in_item req);
            t_out_item res;
            int        k;
            int        hit;
            res      = '0;
            res.last = 1'b1;
            if (req.req_type == REQ_INS_FRONT || req.req_type == REQ_INS_END) begin
                if (count == CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    if (req.req_type == REQ_INS_FRONT) begin
                        head        = (head + CAPACITY - 1) % CAPACITY;
                        cells[head] = req.value;
                    end else begin
                        cells[(head + count) % CAPACITY] = req.value;
                    end
                    count++;
                    res.status = STS_INSERTED;
                end
                owed_q.push_back(res);
            end else if (count == 0) begin
                res.status = STS_EMPTY;
                owed_q.push_back(res);
            end else if (req.req_type == REQ_LIST) begin
                for (k = 0; k < count; k++) begin
                    res.status   = STS_ELEMENT;
                    res.element  = cells[(head + k) % CAPACITY];
                    res.position = 7'(k + 1);
                    res.last     = (k == count - 1);
                    owed_q.push_back(res);
                end
            end else begin
                // First match from the front wins.
                hit = 0;
                for (k = 0; k < count && hit == 0; k++) begin
                    if (cells[(head + k) % CAPACITY] == req.value) hit = k + 1;
                end
                res.status   = (hit != 0) ? STS_FOUND : STS_NOT_FOUND;
                res.position = 7'(hit);
                owed_q.push_back(res);
            end
        endfunction

        function void flag(string what, t_out_item want, t_out_item got);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("%0t: %s: expected status %0d element %h position %0d last %0b,",
                         $realtime, what, want.status, want.element, want.position,
                         want.last);
                $display("    got status %0d element %h position %0d last %0b",
                         got.status, got.element, got.position, got.last);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                flag("result with no request pending", '0, got);
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status || got.element !== want.element ||
                got.position !== want.position || got.last !== want.last) begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_req    = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_res;

    int send_idle_pct  = 31;
    int recv_stall_pct = 82;

    list_scoreboard sb = new();

    ordered_list_with_search_top #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
    end

    // Hold the request until it is taken; idle cycles carry junk payload.
    task automatic send_request(input logic [1:0] kind, input logic signed [31:0] val);
        t_in_item req;
        req.req_type = kind;
        req.value    = val;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_req   <= {2'($urandom()), 32'($urandom())};
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        sb.note_request(req);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(3))
            0, 1:    return 32'($urandom());
            2:       return 32'($urandom_range(7));
            default: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    task automatic run_directed();
        send_request(REQ_LIST,      32'd0);
        send_request(REQ_SEARCH,    32'd0);
        send_request(REQ_INS_END,   32'h7FFF_FFFF);
        send_request(REQ_INS_FRONT, 32'h8000_0000);
        send_request(REQ_INS_END,   32'hFFFF_FFFF);
        send_request(REQ_INS_FRONT, 32'h0000_0000);
        send_request(REQ_LIST,      32'd0);
        send_request(REQ_SEARCH,    32'h8000_0000);
        send_request(REQ_SEARCH,    32'h7FFF_FFFF);
        send_request(REQ_SEARCH,    32'd12345);
        // duplicate value: search must report the front-most copy
        send_request(REQ_INS_END,   32'h0000_0000);
        send_request(REQ_SEARCH,    32'h0000_0000);
        send_request(REQ_INS_FRONT, 32'h5555_5555);
        send_request(REQ_INS_END,   32'hAAAA_AAAA);
        send_request(REQ_SEARCH,    32'hFFFF_FFFF);
        send_request(REQ_SEARCH,    32'hAAAA_AAAA);
        send_request(REQ_LIST,      32'hFFFF_FFFF);
    endtask

    task automatic run_random(input int n);
        int                 pick;
        logic [1:0]         kind;
        logic signed [31:0] val;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 18)      kind = REQ_INS_FRONT;
            else if (pick < 36) kind = REQ_INS_END;
            else if (pick < 46) kind = REQ_LIST;
            else                kind = REQ_SEARCH;
            if (kind == REQ_SEARCH && sb.count > 0 && $urandom_range(99) < 65) begin
                val = sb.stored_value();
            end else begin
                val = random_value();
            end
            send_request(kind, val);
        end
    endtask

    initial begin
        #10_000_000;
        $display("tb_ordered_list_with_search_top failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(134);
        send_idle_pct  = 82;
        recv_stall_pct = 31;
        run_random(133);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(133);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("tb_ordered_list_with_search_top passed");
        end else begin
            $display("tb_ordered_list_with_search_top failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/olws_pkg.sv
src/olws_cell.sv
src/ordered_list_with_search_top.sv
tb/tb_ordered_list_with_search_top.sv
